// File: rtl/fxalu_pkg.sv
// Package: opcodes, status codes and default widths of the fixed-point ALU.
`default_nettype none
package fxalu_pkg;
	localparam int FracBits  = 8;
	localparam int WordWidth = 32;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_LT = 4'd4, OP_GT = 4'd5, OP_LE = 4'd6, OP_GE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_SAT = 2'd1, ST_DIV0 = 2'd2
	} status_t;
endpackage
`default_nettype wire

// File: rtl/fxalu_mul.sv
// Pipelined signed fixed-point multiplier: product, shift, saturate.
`default_nettype none
module fxalu_mul import fxalu_pkg::*; #(
	parameter int FRAC_BITS  = FracBits,
	parameter int WORD_WIDTH = WordWidth
) (
	input  wire                         clk,
	input  wire logic [WORD_WIDTH-1:0]  a,
	input  wire logic [WORD_WIDTH-1:0]  b,
	output logic [WORD_WIDTH-1:0]       prod,
	output logic                        sat
);
	localparam int PW = 2 * WORD_WIDTH;
	logic signed [WORD_WIDTH-1:0] a_s1, b_s1;
	logic signed [PW-1:0]         p_s2;
	logic signed [PW-1:0]         sh;
	logic                         hi_ok;

	// operand register then product register
	always_ff @(posedge clk) begin
		a_s1 <= a;
		b_s1 <= b;
		p_s2 <= PW'(a_s1) * PW'(b_s1);
	end

	// shift toward zero: add bias for negative products before the arithmetic shift
	always_comb begin
		sh = $signed(p_s2 + (p_s2[PW-1] ? PW'((64'd1 << FRAC_BITS) - 64'd1) : PW'(0)))
			>>> FRAC_BITS;
		hi_ok = (sh[PW-1:WORD_WIDTH-1] == {(PW-WORD_WIDTH+1){1'b0}})
			|| (sh[PW-1:WORD_WIDTH-1] == {(PW-WORD_WIDTH+1){1'b1}});
		sat  = !hi_ok;
		prod = hi_ok ? sh[WORD_WIDTH-1:0]
			: (sh[PW-1] ? {1'b1, {(WORD_WIDTH-1){1'b0}}} : {1'b0, {(WORD_WIDTH-1){1'b1}}});
	end
endmodule
`default_nettype wire

// File: rtl/fxalu_div.sv
// Pipelined restoring divider: one quotient bit per stage, magnitudes.
`default_nettype none
module fxalu_div import fxalu_pkg::*; #(
	parameter int FRAC_BITS  = FracBits,
	parameter int WORD_WIDTH = WordWidth
) (
	input  wire                         clk,
	input  wire logic [WORD_WIDTH-1:0]  mag_a,
	input  wire logic [WORD_WIDTH-1:0]  mag_b,
	output logic [WORD_WIDTH+FRAC_BITS-1:0] quo
);
	localparam int NW = WORD_WIDTH + FRAC_BITS;
	localparam int RW = WORD_WIDTH + 1;

	logic [NW-1:0]         num_q [1:NW];
	logic [NW-1:0]         qt_q  [1:NW];
	logic [RW-1:0]         rem_q [1:NW];
	logic [WORD_WIDTH-1:0] den_q [1:NW];

	// each stage brings down one numerator bit
	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [NW-1:0]         num_c, qt_c;
		logic [RW-1:0]         rem_c;
		logic [WORD_WIDTH-1:0] den_c;
		logic [RW-1:0]         t;
		logic                  ge;
		// first stage takes the operands, later stages the previous registers
		if (i == 0) begin : g_first
			assign num_c = {mag_a, {FRAC_BITS{1'b0}}};
			assign qt_c  = '0;
			assign rem_c = '0;
			assign den_c = mag_b;
		end else begin : g_next
			assign num_c = num_q[i];
			assign qt_c  = qt_q[i];
			assign rem_c = rem_q[i];
			assign den_c = den_q[i];
		end
		always_comb begin
			t  = {rem_c[RW-2:0], num_c[NW-1]};
			ge = t >= RW'(den_c);
		end
		always_ff @(posedge clk) begin
			num_q[i+1] <= {num_c[NW-2:0], 1'b0};
			qt_q[i+1]  <= {qt_c[NW-2:0], ge};
			rem_q[i+1] <= ge ? t - RW'(den_c) : t;
			den_q[i+1] <= den_c;
		end
	end
	assign quo = qt_q[NW];
endmodule
`default_nettype wire

// File: rtl/fixed_point_q24_8_alu.sv
// Top level: pipelined signed Q24.8 fixed-point ALU.
// Usage: drive opcode, operand_a, operand_b and pulse start while busy is
// low; one transaction is taken per cycle. busy is held low: the pipeline
// takes a new transaction every clock.
// Each transaction yields one result on result, compare_true and status,
// marked by done for exactly one cycle, in issue order.
// All opcodes share one pipeline depth; it is set by the divider, one quotient
// bit per stage. Other opcodes travel a delay line alongside so results stay
// in order.
// Throughput: one transaction per cycle.
// Reset clears all valid bits; no result comes out until items are issued.
// The receiver cannot stall; results must be taken when done is high.
`default_nettype none
module fixed_point_q24_8_alu import fxalu_pkg::*; #(
	parameter int FRAC_BITS  = FracBits,
	parameter int WORD_WIDTH = WordWidth
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire logic [3:0]                   opcode,
	input  wire logic signed [WORD_WIDTH-1:0] operand_a,
	input  wire logic signed [WORD_WIDTH-1:0] operand_b,
	output logic                              done,
	output logic signed [WORD_WIDTH-1:0]      result,
	output logic                              compare_true,
	output logic [1:0]                        status
);
	localparam int NW  = WORD_WIDTH + FRAC_BITS;
	localparam logic [WORD_WIDTH-1:0] MaxW = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	localparam logic [WORD_WIDTH-1:0] MinW = {1'b1, {(WORD_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic [WORD_WIDTH-1:0] res;
		logic                  cmp;
		logic [1:0]            st;
		logic                  is_mul;
		logic                  is_div;
		logic                  neg;
	} pend_t;

	assign busy = 1'b0;

	// stage 1: register inputs
	logic                  v_s1;
	logic [3:0]            op_s1;
	logic [WORD_WIDTH-1:0] a_s1, b_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		op_s1 <= opcode;
		a_s1  <= operand_a;
		b_s1  <= operand_b;
	end

	// simple ops evaluated from stage 1
	logic signed [WORD_WIDTH:0] sum, dif;
	logic lt_ab, lt_ba;
	logic [WORD_WIDTH-1:0] mag_a, mag_b;
	logic signed [WORD_WIDTH-1:0] sa, sb;
	pend_t pe;
	always_comb begin
		sa = a_s1;
		sb = b_s1;
		sum = (WORD_WIDTH+1)'(sa) + (WORD_WIDTH+1)'(sb);
		dif = (WORD_WIDTH+1)'(sa) - (WORD_WIDTH+1)'(sb);
		lt_ab = sa < sb;
		lt_ba = sb < sa;
		mag_a = a_s1[WORD_WIDTH-1] ? WORD_WIDTH'(-a_s1) : a_s1;
		mag_b = b_s1[WORD_WIDTH-1] ? WORD_WIDTH'(-b_s1) : b_s1;
		pe = '0;
		pe.neg = a_s1[WORD_WIDTH-1] ^ b_s1[WORD_WIDTH-1];
		case (op_t'(op_s1))
			OP_ADD: begin
				if (sum[WORD_WIDTH] != sum[WORD_WIDTH-1]) begin
					pe.res = sum[WORD_WIDTH] ? MinW : MaxW; pe.st = ST_SAT;
				end else pe.res = sum[WORD_WIDTH-1:0];
			end
			OP_SUB: begin
				if (dif[WORD_WIDTH] != dif[WORD_WIDTH-1]) begin
					pe.res = dif[WORD_WIDTH] ? MinW : MaxW; pe.st = ST_SAT;
				end else pe.res = dif[WORD_WIDTH-1:0];
			end
			OP_MUL: pe.is_mul = 1'b1;
			OP_DIV: begin
				if (b_s1 == '0) pe.st = ST_DIV0;
				else pe.is_div = 1'b1;
			end
			OP_LT: pe.cmp = lt_ab;
			OP_GT: pe.cmp = lt_ba;
			OP_LE: pe.cmp = !lt_ba;
			OP_GE: pe.cmp = !lt_ab;
			OP_EQ: pe.cmp = a_s1 == b_s1;
			OP_NE: pe.cmp = a_s1 != b_s1;
			OP_MIN: pe.res = lt_ba ? b_s1 : a_s1;
			OP_MAX: pe.res = lt_ab ? b_s1 : a_s1;
			OP_INC: begin
				if (a_s1 == MaxW) begin pe.res = a_s1; pe.st = ST_SAT; end
				else pe.res = a_s1 + 1'b1;
			end
			OP_DEC: begin
				if (a_s1 == MinW) begin pe.res = a_s1; pe.st = ST_SAT; end
				else pe.res = a_s1 - 1'b1;
			end
			OP_FROM_INT: begin
				if (sa > $signed(MaxW >> FRAC_BITS)
						|| sa < $signed(MinW) >>> FRAC_BITS) begin
					pe.res = sa[WORD_WIDTH-1] ? MinW : MaxW; pe.st = ST_SAT;
				end else pe.res = a_s1 << FRAC_BITS;
			end
			OP_TO_INT: pe.res = WORD_WIDTH'(sa >>> FRAC_BITS);
			default: pe = '0;
		endcase
	end

	// multiplier: two registers, result seen at stage 3
	logic [WORD_WIDTH-1:0] mprod;
	logic                  msat;
	fxalu_mul #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(WORD_WIDTH)) u_mul (
		.clk(clk), .a(a_s1), .b(b_s1), .prod(mprod), .sat(msat)
	);

	// divider: NW registers, quotient seen at stage NW+1
	logic [NW-1:0] quo;
	fxalu_div #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(WORD_WIDTH)) u_div (
		.clk(clk), .mag_a(mag_a), .mag_b(mag_b), .quo(quo)
	);

	// delay line carries control and simple results; pd_q[k] is at stage k+2,
	// mres_q[k] and msat_q[k] line up with pd_q[k+2]
	pend_t pd_q [NW];
	logic  vd_q [NW];
	logic [WORD_WIDTH-1:0] mres_q [NW-2];
	logic  msat_q [NW-2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NW; k++) vd_q[k] <= 1'b0;
		end else begin
			vd_q[0] <= v_s1;
			for (int k = 1; k < NW; k++) vd_q[k] <= vd_q[k-1];
		end
	end
	always_ff @(posedge clk) begin
		pd_q[0] <= pe;
		for (int k = 1; k < NW; k++) pd_q[k] <= pd_q[k-1];
		mres_q[0] <= mprod;
		msat_q[0] <= msat;
		for (int k = 1; k < NW-2; k++) begin
			mres_q[k] <= mres_q[k-1];
			msat_q[k] <= msat_q[k-1];
		end
	end

	// final stage: merge, finish divide with sign and saturation
	pend_t                 pf;
	logic [NW-1:0]         qneg;
	logic [WORD_WIDTH-1:0] fres;
	logic [1:0]            fst;
	always_comb begin
		pf   = pd_q[NW-1];
		fres = pf.res;
		fst  = pf.st;
		qneg = -quo;
		if (pf.is_mul) begin
			fres = mres_q[NW-3];
			fst  = msat_q[NW-3] ? ST_SAT : ST_OK;
		end else if (pf.is_div) begin
			if (!pf.neg) begin
				if (quo > NW'(MaxW)) begin fres = MaxW; fst = ST_SAT; end
				else fres = quo[WORD_WIDTH-1:0];
			end else begin
				if (quo > NW'(MinW)) begin fres = MinW; fst = ST_SAT; end
				else fres = qneg[WORD_WIDTH-1:0];
			end
		end
	end

	logic v_o;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_o <= 1'b0;
		else v_o <= vd_q[NW-1];
	end
	always_ff @(posedge clk) begin
		result       <= fres;
		compare_true <= pf.cmp;
		status       <= fst;
	end
	assign done = v_o;
endmodule
`default_nettype wire
